// ===== rtl/hrhp_pkg.sv =====
// shared types, constants and token tables for the http request head parser
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package hrhp_pkg;

  // longest request head accepted, in bytes
  localparam int unsigned MAX_REQUEST = 4096;
  localparam int unsigned BC_W        = $clog2(MAX_REQUEST + 1);

  // depth of the queue between front and back
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);
  localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);

  // status codes
  localparam logic [1:0] ST_MORE = 2'd0;
  localparam logic [1:0] ST_GET  = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  // classified input byte
  typedef struct packed {
    logic [7:0] data;
    logic [7:0] lc;
    logic       new_req;
    logic       is_blank;
    logic       is_cr;
    logic       is_lf;
    logic       is_slash;
  } item_t;

  // one result
  typedef struct packed {
    logic [1:0] status;
    logic [7:0] data;
    logic       url_tag;
    logic       host_tag;
  } res_t;

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= 8'h41 && b <= 8'h5a) begin
      r = b + 8'd32;
    end
    return r;
  endfunction

  function automatic logic [7:0] get_ch(input logic [1:0] i);
    logic [7:0] c;
    case (i)
      2'd0:    c = 8'h67; // g
      2'd1:    c = 8'h65; // e
      default: c = 8'h74; // t
    endcase
    return c;
  endfunction

  function automatic logic [7:0] ver_ch(input logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0:    c = 8'h68; // h
      3'd1:    c = 8'h74; // t
      3'd2:    c = 8'h74; // t
      3'd3:    c = 8'h70; // p
      3'd4:    c = 8'h2f; // /
      3'd5:    c = 8'h31; // 1
      3'd6:    c = 8'h2e; // .
      default: c = 8'h31; // 1
    endcase
    return c;
  endfunction

  function automatic logic [7:0] pre_ch(input logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0:    c = 8'h68; // h
      3'd1:    c = 8'h74; // t
      3'd2:    c = 8'h74; // t
      3'd3:    c = 8'h70; // p
      3'd4:    c = 8'h3a; // :
      3'd5:    c = 8'h2f; // /
      3'd6:    c = 8'h2f; // /
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] host_ch(input logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0:    c = 8'h68; // h
      3'd1:    c = 8'h6f; // o
      3'd2:    c = 8'h73; // s
      3'd3:    c = 8'h74; // t
      3'd4:    c = 8'h3a; // :
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/http_request_head_parser_unit.sv =====
// top level of the http request head parser: front classifier, queue, back parser
// depends on hrhp_pkg, hrhp_front, hrhp_queue, hrhp_back
//
//  channel   dir  tdata                               tuser
//  s_axis    in   [7:0] data_byte                     [0] new_request
//  m_axis    out  [1:0] status, [9:2] out_byte        [0] url_tag, [1] host_tag
//
// one byte a cycle sustained while m_axis accepts results; a byte's result is valid on m_axis
// after the front register, the queue write and then the back parse into the output register
// the parser state steps once per byte in the back stage, which sets the rate
// rst_ni clears the parser to the request-line start and empties all stages
// a stall on m_axis holds the output register; the queue and front keep taking bytes
// until the queue and front register are full, then s_axis_tready falls
`timescale 1ns / 1ps
`default_nettype none

module http_request_head_parser_unit import hrhp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  wire logic        s_axis_tuser,  // [0] new_request
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,  // [1:0] status, [9:2] out_byte, rest zero
  output logic [1:0]       m_axis_tuser   // [0] url_tag, [1] host_tag
);

  // front to queue
  logic  f_valid, f_ready;
  item_t f_item;
  // queue to back
  logic  q_valid, q_ready;
  item_t q_item;
  // back result
  res_t  res;

  // classify each byte (blank, cr, lf, slash, lower case) on its way in
  hrhp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .in_new_i     (s_axis_tuser),
    .item_valid_o (f_valid),
    .item_ready_i (f_ready),
    .item_o       (f_item)
  );

  // short queue so the input side keeps going while the output stalls
  hrhp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_item_i  (f_item),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_item_o   (q_item)
  );

  // parser state machine and output register
  hrhp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_ready_o (q_ready),
    .item_i       (q_item),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_o        (res)
  );

  // pack the result, padding tdata to whole bytes
  assign m_axis_tdata = {6'd0, res.data, res.status};
  assign m_axis_tuser = {res.host_tag, res.url_tag};

endmodule

`default_nettype wire

// ===== rtl/hrhp_front.sv =====
// front stage: takes input bytes and classifies them into queue items
// depends on hrhp_pkg
`timescale 1ns / 1ps
`default_nettype none

module hrhp_front import hrhp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_data_i,
  input  wire logic       in_new_i,
  output logic            item_valid_o,
  input  wire logic       item_ready_i,
  output item_t           item_o
);

  logic  v_q, v_d;
  item_t item_q, item_d;
  logic  load;

  assign in_ready_o = !v_q || item_ready_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    item_d          = item_q;
    item_d.data     = in_data_i;
    item_d.lc       = to_lower(in_data_i);
    item_d.new_req  = in_new_i;
    item_d.is_blank = (in_data_i == 8'h20) || (in_data_i == 8'h09);
    item_d.is_cr    = (in_data_i == 8'h0d);
    item_d.is_lf    = (in_data_i == 8'h0a);
    item_d.is_slash = (in_data_i == 8'h2f);
    v_d             = load || (v_q && !item_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_d;
    end
  end

  assign item_valid_o = v_q;
  assign item_o       = item_q;

endmodule

`default_nettype wire

// ===== rtl/hrhp_queue.sv =====
// short item queue between the front and back stages
// depends on hrhp_pkg
`timescale 1ns / 1ps
`default_nettype none

module hrhp_queue import hrhp_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_valid_i,
  output logic       push_ready_o,
  input  wire item_t push_item_i,
  output logic       pop_valid_o,
  input  wire logic  pop_ready_i,
  output item_t      pop_item_o
);

  item_t            mem_q [Q_DEPTH];
  logic [Q_AW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [Q_CW-1:0]  cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != Q_CW'(Q_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = push ? wr_q + 1'b1 : wr_q;
    rd_d  = pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Q_CW'(Q_DEPTH))
    else $error("queue count beyond depth");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != Q_CW'(Q_DEPTH)) && (cnt_q != '0) |-> wr_q != rd_q)
    else $error("queue pointers collide while partly full");
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count missed a push");
`endif

endmodule

`default_nettype wire

// ===== rtl/hrhp_back.sv =====
// back stage: request line and header parser with output register
// depends on hrhp_pkg
`timescale 1ns / 1ps
`default_nettype none

module hrhp_back import hrhp_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  item_valid_i,
  output logic       item_ready_o,
  input  wire item_t item_i,
  output logic       res_valid_o,
  input  wire logic  res_ready_i,
  output res_t       res_o
);

  // request line phases
  localparam logic [2:0] FP_METH = 3'd0;
  localparam logic [2:0] FP_B1   = 3'd1;
  localparam logic [2:0] FP_URL  = 3'd2;
  localparam logic [2:0] FP_B2   = 3'd3;
  localparam logic [2:0] FP_VER  = 3'd4;
  // url modes
  localparam logic [1:0] UM_PRE  = 2'd0;
  localparam logic [1:0] UM_SEEK = 2'd1;
  localparam logic [1:0] UM_PATH = 2'd2;
  localparam logic [1:0] UM_BAD  = 2'd3;
  // header phases
  localparam logic [2:0] HP_START = 3'd0;
  localparam logic [2:0] HP_HOST  = 3'd1;
  localparam logic [2:0] HP_BLANK = 3'd2;
  localparam logic [2:0] HP_VAL   = 3'd3;
  localparam logic [2:0] HP_OTHER = 3'd4;

  typedef struct packed {
    logic [1:0] um;
    logic [3:0] mi;
  } url_t;

  function automatic url_t url_step(input url_t s, input logic [7:0] lc,
                                    input logic slash);
    url_t r;
    r = s;
    if (s.um == UM_PRE) begin
      if (s.mi < 4'd7 && lc == pre_ch(s.mi[2:0])) begin
        r.mi = s.mi + 4'd1;
        if (r.mi == 4'd7) begin
          r.um = UM_SEEK;
        end
      end else if (s.mi == 4'd0 && slash) begin
        r.um = UM_PATH;
      end else begin
        r.um = UM_BAD;
      end
    end else if (s.um == UM_SEEK && slash) begin
      r.um = UM_PATH;
    end
    return r;
  endfunction

  logic            lk_q, lk_d;
  logic [2:0]      fp_q, fp_d;
  logic [3:0]      mi_q, mi_d;
  logic            tok_q, tok_d;
  logic [1:0]      um_q, um_d;
  logic            pcr_q, pcr_d;
  logic [2:0]      hp_q, hp_d;
  logic [1:0]      vd_q, vd_d;
  logic [BC_W-1:0] bc_q, bc_d;
  logic            ut, ht;
  url_t            us;
  logic            o_v_q, o_v_d;
  res_t            res_q, res_d;
  logic            pop;

  assign item_ready_o = !o_v_q || res_ready_i;
  assign pop          = item_valid_i && item_ready_o;

  always_comb begin
    lk_d  = lk_q;
    fp_d  = fp_q;
    mi_d  = mi_q;
    tok_d = tok_q;
    um_d  = um_q;
    pcr_d = pcr_q;
    hp_d  = hp_q;
    vd_d  = vd_q;
    bc_d  = bc_q;
    ut    = 1'b0;
    ht    = 1'b0;
    us    = '0;
    if (item_i.new_req) begin
      lk_d  = 1'b0;
      fp_d  = FP_METH;
      mi_d  = '0;
      tok_d = 1'b1;
      um_d  = UM_PRE;
      pcr_d = 1'b0;
      hp_d  = HP_START;
      vd_d  = ST_MORE;
      bc_d  = '0;
    end
    if (vd_d == ST_MORE) begin
      if (bc_d >= BC_W'(MAX_REQUEST)) begin
        vd_d = ST_BAD;
      end else begin
        bc_d = bc_d + 1'b1;
        if (pcr_d) begin
          pcr_d = 1'b0;
          if (!item_i.is_lf) begin
            vd_d = ST_BAD;
          end else if (!lk_d) begin
            if (tok_d && fp_d == FP_VER && mi_d == 4'd8) begin
              lk_d = 1'b1;
              hp_d = HP_START;
              mi_d = '0;
            end else begin
              vd_d = ST_BAD;
            end
          end else if (hp_d == HP_START) begin
            vd_d = ST_GET;
          end else begin
            hp_d = HP_START;
            mi_d = '0;
          end
        end else if (item_i.is_cr) begin
          pcr_d = 1'b1;
        end else if (item_i.is_lf) begin
          vd_d = ST_BAD;
        end else if (!lk_d) begin
          case (fp_d)
            FP_METH: begin
              if (item_i.is_blank) begin
                if (mi_d != 4'd3) begin
                  tok_d = 1'b0;
                end
                fp_d = FP_B1;
              end else if (mi_d < 4'd3 && item_i.lc == get_ch(mi_d[1:0])) begin
                mi_d = mi_d + 4'd1;
              end else begin
                tok_d = 1'b0;
              end
            end
            FP_B1: begin
              if (!item_i.is_blank) begin
                fp_d = FP_URL;
                us   = url_step('{um: UM_PRE, mi: 4'd0}, item_i.lc, item_i.is_slash);
                um_d = us.um;
                mi_d = us.mi;
                ut   = (um_d == UM_PATH) && tok_d;
              end
            end
            FP_URL: begin
              if (item_i.is_blank) begin
                if (um_d != UM_PATH) begin
                  tok_d = 1'b0;
                end
                fp_d = FP_B2;
              end else begin
                us   = url_step('{um: um_d, mi: mi_d}, item_i.lc, item_i.is_slash);
                um_d = us.um;
                mi_d = us.mi;
                ut   = (um_d == UM_PATH) && tok_d;
              end
            end
            FP_B2: begin
              if (!item_i.is_blank) begin
                fp_d = FP_VER;
                if (item_i.lc == ver_ch(3'd0)) begin
                  mi_d = 4'd1;
                end else begin
                  mi_d  = '0;
                  tok_d = 1'b0;
                end
              end
            end
            FP_VER: begin
              if (mi_d < 4'd8 && item_i.lc == ver_ch(mi_d[2:0])) begin
                mi_d = mi_d + 4'd1;
              end else begin
                tok_d = 1'b0;
              end
            end
            default: begin
              tok_d = 1'b0;
            end
          endcase
        end else begin
          if (hp_d == HP_START) begin
            hp_d = HP_HOST;
            mi_d = '0;
          end
          case (hp_d)
            HP_HOST: begin
              if (mi_d < 4'd5 && item_i.lc == host_ch(mi_d[2:0])) begin
                mi_d = mi_d + 4'd1;
                if (mi_d == 4'd5) begin
                  hp_d = HP_BLANK;
                end
              end else begin
                hp_d = HP_OTHER;
              end
            end
            HP_BLANK: begin
              if (!item_i.is_blank) begin
                hp_d = HP_VAL;
                ht   = 1'b1;
              end
            end
            HP_VAL: begin
              ht = 1'b1;
            end
            default: begin
              ht = 1'b0;
            end
          endcase
        end
        if (vd_d != ST_MORE) begin
          ut = 1'b0;
          ht = 1'b0;
        end
      end
    end
    res_d.status   = vd_d;
    res_d.data     = item_i.data;
    res_d.url_tag  = ut;
    res_d.host_tag = ht;
    o_v_d          = pop || (o_v_q && !res_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lk_q  <= 1'b0;
      fp_q  <= FP_METH;
      mi_q  <= '0;
      tok_q <= 1'b1;
      um_q  <= UM_PRE;
      pcr_q <= 1'b0;
      hp_q  <= HP_START;
      vd_q  <= ST_MORE;
      bc_q  <= '0;
      o_v_q <= 1'b0;
    end else begin
      o_v_q <= o_v_d;
      if (pop) begin
        lk_q  <= lk_d;
        fp_q  <= fp_d;
        mi_q  <= mi_d;
        tok_q <= tok_d;
        um_q  <= um_d;
        pcr_q <= pcr_d;
        hp_q  <= hp_d;
        vd_q  <= vd_d;
        bc_q  <= bc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = o_v_q;
  assign res_o       = res_q;

`ifndef SYNTH
  a_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !item_i.new_req && vd_q != ST_MORE |=> vd_q == $past(vd_q))
    else $error("verdict changed without a new request");
  a_tags_on_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_v_q && res_q.status != ST_MORE |-> !res_q.url_tag && !res_q.host_tag)
    else $error("tag set on a terminal status");
  a_one_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_v_q |-> !(res_q.url_tag && res_q.host_tag))
    else $error("url and host tag both set");
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bc_q <= BC_W'(MAX_REQUEST))
    else $error("byte count beyond limit");
`endif

endmodule

`default_nettype wire
